// ===== rtl/nand_logical_block_map_defines.svh =====
// Assertion macros shared by the checker of the logical block map.
`ifndef NAND_LOGICAL_BLOCK_MAP_DEFINES_SVH
`define NAND_LOGICAL_BLOCK_MAP_DEFINES_SVH

// Overlapping implication checked at every rising clock edge.
`define NLBM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("map checker: implication failed");

// Consequent checked in the cycle after the antecedent.
`define NLBM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("map checker: next-cycle check failed");

// Delayed implication: the consequent is checked later than the antecedent.
`define NLBM_ASSERT_LAT2(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error("map checker: latency check failed");

`endif

// ===== rtl/nlbm_pkg.sv =====
// Types and constants of the logical block map.
package nlbm_pkg;

   localparam int TAG_W      = 16;
   localparam int LB_W       = 10;
   localparam int ADDR_W     = 32;
   localparam int PA_OUT_W   = 36;
   localparam int COUNT_W    = 10;
   localparam int SHIFT_W    = 5;
   localparam int PHYS_IN_W  = 12;
   localparam int CSR_DATA_W = 10;

   localparam logic [TAG_W-1:0]   TAG_RESERVED = 16'hFFFF;
   localparam logic [TAG_W-1:0]   TAG_NUM_MASK = 16'h07FE;
   localparam logic [COUNT_W-1:0] COUNT_RESET  = 10'd1023;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET  = 5'd14;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_SCAN  = 2'd1,
      OP_XLATE = 2'd2,
      OP_SPARE = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_MAPPED   = 4'd0,
      ST_SKIPPED  = 4'd1,
      ST_NOVOTE   = 4'd2,
      ST_PARITY   = 4'd3,
      ST_RANGE    = 4'd4,
      ST_DUP      = 4'd5,
      ST_XLATED   = 4'd6,
      ST_REJECT   = 4'd7,
      ST_UNMAPPED = 4'd8,
      ST_CLEARED  = 4'd9
   } status_type;

   typedef enum logic [0:0] {
      CSR_LOGICAL_COUNT = 1'b0,
      CSR_BLOCK_SHIFT   = 1'b1
   } csr_type;

   typedef struct packed {
      logic   valid;
      op_type op;
      logic   skip;
      logic   novote;
   } stage_type;

endpackage

// ===== rtl/nlbm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module nlbm_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/nlbm_decode.sv =====
// Input stage: tag vote, table index and the registered item.
module nlbm_decode #(
   parameter int LOGICAL_ENTRIES = 1024,
   parameter int PHYS_BLOCK_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  take,
   input  logic [1:0]                            req_operation,
   input  logic [nlbm_pkg::PHYS_IN_W-1:0]        req_phys_block,
   input  logic                                  req_block_bad,
   input  logic                                  req_read_ok,
   input  logic [7:0]                            req_copy_a_low,
   input  logic [7:0]                            req_copy_a_high,
   input  logic [7:0]                            req_copy_b_low,
   input  logic [7:0]                            req_copy_b_high,
   input  logic [7:0]                            req_copy_c_low,
   input  logic [7:0]                            req_copy_c_high,
   input  logic [nlbm_pkg::ADDR_W-1:0]           req_logical_address,
   input  logic [nlbm_pkg::ADDR_W-1:0]           req_length,
   input  logic [nlbm_pkg::SHIFT_W-1:0]          block_shift,
   output logic [$clog2(LOGICAL_ENTRIES)-1:0]    rd_addr,
   output nlbm_pkg::stage_type                   stage,
   output logic [nlbm_pkg::TAG_W-1:0]            tag,
   output logic [nlbm_pkg::ADDR_W-1:0]           addr,
   output logic [nlbm_pkg::ADDR_W-1:0]           len,
   output logic [PHYS_BLOCK_BITS-1:0]            phys
);
   import nlbm_pkg::*;

   localparam int IDX_W = $clog2(LOGICAL_ENTRIES);
   localparam int PB_EXT_W = (PHYS_BLOCK_BITS > PHYS_IN_W) ? PHYS_BLOCK_BITS : PHYS_IN_W;

   logic [TAG_W-1:0]           tag_a;
   logic [TAG_W-1:0]           tag_b;
   logic [TAG_W-1:0]           tag_c;
   logic [TAG_W-1:0]           vote;
   logic                       novote;
   logic [LB_W-1:0]            num;
   logic [ADDR_W-1:0]          first;
   logic [PB_EXT_W-1:0]        phys_ext;
   op_type                     op;
   stage_type                  stage_ff;
   stage_type                  stage_in;
   logic [TAG_W-1:0]           tag_ff;
   logic [TAG_W-1:0]           tag_in;
   logic [ADDR_W-1:0]          addr_ff;
   logic [ADDR_W-1:0]          addr_in;
   logic [ADDR_W-1:0]          len_ff;
   logic [ADDR_W-1:0]          len_in;
   logic [PHYS_BLOCK_BITS-1:0] phys_ff;
   logic [PHYS_BLOCK_BITS-1:0] phys_in;

   assign tag_a = {req_copy_a_high, req_copy_a_low};
   assign tag_b = {req_copy_b_high, req_copy_b_low};
   assign tag_c = {req_copy_c_high, req_copy_c_low};
   assign op    = op_type'(req_operation);

   always_comb begin
      novote = 1'b0;
      priority if (tag_a == tag_b) begin
         vote = tag_a;
      end else if (tag_b == tag_c) begin
         vote = tag_b;
      end else if (tag_c == tag_a) begin
         vote = tag_c;
      end else begin
         vote   = tag_a;
         novote = 1'b1;
      end
      num      = LB_W'((vote & TAG_NUM_MASK) >> 1);
      first    = req_logical_address >> block_shift;
      phys_ext = PB_EXT_W'(req_phys_block);
      if (op == OP_SCAN) begin
         rd_addr = num[IDX_W-1:0];
      end else begin
         rd_addr = first[IDX_W-1:0];
      end
      stage_in.valid  = take;
      stage_in.op     = op;
      stage_in.skip   = req_block_bad | ~req_read_ok;
      stage_in.novote = novote;
      if (take) begin
         tag_in  = vote;
         addr_in = req_logical_address;
         len_in  = req_length;
         phys_in = phys_ext[PHYS_BLOCK_BITS-1:0];
      end else begin
         tag_in  = tag_ff;
         addr_in = addr_ff;
         len_in  = len_ff;
         phys_in = phys_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
      tag_ff  <= tag_in;
      addr_ff <= addr_in;
      len_ff  <= len_in;
      phys_ff <= phys_in;
   end

   assign stage = stage_ff;
   assign tag   = tag_ff;
   assign addr  = addr_ff;
   assign len   = len_ff;
   assign phys  = phys_ff;

endmodule

// ===== rtl/nlbm_resolve.sv =====
// Result stage: checks, table update request, address translation and result registers.
module nlbm_resolve #(
   parameter int LOGICAL_ENTRIES = 1024,
   parameter int PHYS_BLOCK_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  nlbm_pkg::stage_type                   stage,
   input  logic [nlbm_pkg::TAG_W-1:0]            tag,
   input  logic [nlbm_pkg::ADDR_W-1:0]           addr,
   input  logic [nlbm_pkg::ADDR_W-1:0]           len,
   input  logic [PHYS_BLOCK_BITS-1:0]            phys,
   input  logic                                  rd_mapped,
   input  logic [PHYS_BLOCK_BITS-1:0]            rd_phys,
   input  logic [nlbm_pkg::COUNT_W-1:0]          logical_count,
   input  logic [nlbm_pkg::SHIFT_W-1:0]          block_shift,
   output logic                                  wr_en,
   output logic [$clog2(LOGICAL_ENTRIES)-1:0]    wr_addr,
   output logic [PHYS_BLOCK_BITS-1:0]            wr_phys,
   output logic                                  sweep_go,
   output logic                                  rsp_valid,
   output logic [3:0]                            rsp_status,
   output logic [nlbm_pkg::LB_W-1:0]             rsp_logical_block,
   output logic [nlbm_pkg::PA_OUT_W-1:0]         rsp_physical_address
);
   import nlbm_pkg::*;

   localparam int IDX_W = $clog2(LOGICAL_ENTRIES);
   localparam int PA_W  = PHYS_BLOCK_BITS + ADDR_W;
   localparam logic [LB_W:0] ENTRIES_LIM = (LB_W + 1)'(LOGICAL_ENTRIES);

   logic [LB_W-1:0]     num;
   logic                num_bad;
   logic [ADDR_W-1:0]   first;
   logic [ADDR_W:0]     last_sum;
   logic                crosses;
   logic                first_bad;
   logic [ADDR_W-1:0]   offs;
   logic [PA_W-1:0]     pa_wide;
   logic                valid_ff;
   logic                valid_in;
   status_type          status_ff;
   status_type          status_in;
   logic [LB_W-1:0]     lb_ff;
   logic [LB_W-1:0]     lb_in;
   logic [PA_OUT_W-1:0] pa_ff;
   logic [PA_OUT_W-1:0] pa_in;

   always_comb begin
      num       = LB_W'((tag & TAG_NUM_MASK) >> 1);
      num_bad   = (num >= logical_count) || ({1'b0, num} >= ENTRIES_LIM);
      first     = addr >> block_shift;
      last_sum  = {1'b0, addr} + {1'b0, len} - (ADDR_W + 1)'(1);
      crosses   = ((last_sum ^ {1'b0, addr}) >> block_shift) != '0;
      first_bad = (first >= ADDR_W'(logical_count)) || (first >= ADDR_W'(LOGICAL_ENTRIES));
      offs      = addr & ~({ADDR_W{1'b1}} << block_shift);
      pa_wide   = (PA_W'(rd_phys) << block_shift) | PA_W'(offs);

      valid_in  = stage.valid;
      status_in = ST_REJECT;
      lb_in     = '0;
      pa_in     = '0;
      wr_en     = 1'b0;
      sweep_go  = 1'b0;
      wr_addr   = num[IDX_W-1:0];
      wr_phys   = phys;

      unique case (stage.op)
         OP_CLEAR: begin
            status_in = ST_CLEARED;
            sweep_go  = stage.valid;
         end
         OP_SCAN: begin
            priority if (stage.skip) begin
               status_in = ST_SKIPPED;
            end else if (stage.novote) begin
               status_in = ST_NOVOTE;
            end else if (^tag) begin
               status_in = ST_PARITY;
            end else if (tag == TAG_RESERVED) begin
               status_in = ST_RANGE;
            end else if (num_bad) begin
               status_in = ST_RANGE;
               lb_in     = num;
            end else if (rd_mapped) begin
               status_in = ST_DUP;
               lb_in     = num;
            end else begin
               status_in = ST_MAPPED;
               lb_in     = num;
               wr_en     = stage.valid;
            end
         end
         OP_XLATE: begin
            priority if (len == '0 || first_bad || crosses) begin
               status_in = ST_REJECT;
            end else if (!rd_mapped) begin
               status_in = ST_UNMAPPED;
               lb_in     = first[LB_W-1:0];
            end else begin
               status_in = ST_XLATED;
               lb_in     = first[LB_W-1:0];
               pa_in     = pa_wide[PA_OUT_W-1:0];
            end
         end
         OP_SPARE: begin
            status_in = ST_REJECT;
         end
         default: begin
            status_in = ST_REJECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      status_ff <= status_in;
      lb_ff     <= lb_in;
      pa_ff     <= pa_in;
   end

   assign rsp_valid            = valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_logical_block    = lb_ff;
   assign rsp_physical_address = pa_ff;

endmodule

// ===== rtl/nand_logical_block_map.sv =====
// Top level of the logical-to-physical flash block map.
//
// An item is taken at a rising edge with start high and busy low. Its
// operation selects clear, scan of one physical block, or translate of a
// logical byte range; the spare code is rejected. Each item gives exactly
// one result, shown on the rsp_ ports for a single cycle with rsp_valid
// high; the receiver cannot hold it off.
// At the accepting edge the item is registered and the map memory is read at
// the voted tag's logical number or at the addressed logical block. From those
// registers the result stage checks, updates the entry and registers the
// result, which raises rsp_valid. Busy stays high while the item sits in the
// item registers, so no new item is taken before the last is through, as the
// memory read-modify-write requires.
// A clear item, and also reset, sweeps the whole map one entry per cycle
// with busy held high, so the item after a clear is taken only once the
// sweep has passed the last entry; the clear result comes out while the
// sweep runs.
// The csr_ port is always ready; index 0 writes the logical block count and
// index 1 the block size shift. Write it only while the block is idle.
module nand_logical_block_map #(
   parameter int LOGICAL_ENTRIES = 1024,
   parameter int PHYS_BLOCK_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_operation,
   input  logic [nlbm_pkg::PHYS_IN_W-1:0]       req_phys_block,
   input  logic                                 req_block_bad,
   input  logic                                 req_read_ok,
   input  logic [7:0]                           req_copy_a_low,
   input  logic [7:0]                           req_copy_a_high,
   input  logic [7:0]                           req_copy_b_low,
   input  logic [7:0]                           req_copy_b_high,
   input  logic [7:0]                           req_copy_c_low,
   input  logic [7:0]                           req_copy_c_high,
   input  logic [nlbm_pkg::ADDR_W-1:0]          req_logical_address,
   input  logic [nlbm_pkg::ADDR_W-1:0]          req_length,
   output logic                                 rsp_valid,
   output logic [3:0]                           rsp_status,
   output logic [nlbm_pkg::LB_W-1:0]            rsp_logical_block,
   output logic [nlbm_pkg::PA_OUT_W-1:0]        rsp_physical_address,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic                                 csr_index,
   input  logic [nlbm_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import nlbm_pkg::*;

   localparam int IDX_W = $clog2(LOGICAL_ENTRIES);
   localparam int MAP_W = PHYS_BLOCK_BITS + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LOGICAL_ENTRIES - 1);

   logic [COUNT_W-1:0]         count_ff;
   logic [COUNT_W-1:0]         count_in;
   logic [SHIFT_W-1:0]         shift_ff;
   logic [SHIFT_W-1:0]         shift_in;
   logic                       sweep_ff;
   logic                       sweep_in;
   logic [IDX_W-1:0]           sweep_idx_ff;
   logic [IDX_W-1:0]           sweep_idx_in;
   logic                       take;
   logic [IDX_W-1:0]           rd_addr;
   logic [MAP_W-1:0]           rd_data;
   stage_type                  stage;
   logic [TAG_W-1:0]           tag;
   logic [ADDR_W-1:0]          addr;
   logic [ADDR_W-1:0]          len;
   logic [PHYS_BLOCK_BITS-1:0] phys;
   logic                       res_wr_en;
   logic [IDX_W-1:0]           res_wr_addr;
   logic [PHYS_BLOCK_BITS-1:0] res_wr_phys;
   logic                       sweep_go;
   logic                       mem_wr_en;
   logic [IDX_W-1:0]           mem_wr_addr;
   logic [MAP_W-1:0]           mem_wr_data;

   assign busy      = stage.valid | sweep_ff;
   assign take      = start & ~busy;
   assign csr_ready = 1'b1;

   always_comb begin
      count_in = count_ff;
      shift_in = shift_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_type'(csr_index))
            CSR_LOGICAL_COUNT: count_in = csr_wdata[COUNT_W-1:0];
            CSR_BLOCK_SHIFT:   shift_in = csr_wdata[SHIFT_W-1:0];
            default:           count_in = count_ff;
         endcase
      end
      sweep_in     = sweep_ff;
      sweep_idx_in = sweep_idx_ff;
      if (sweep_ff) begin
         sweep_idx_in = sweep_idx_ff + IDX_W'(1);
         if (sweep_idx_ff == LAST_IDX) begin
            sweep_in = 1'b0;
         end
      end else if (sweep_go) begin
         sweep_in     = 1'b1;
         sweep_idx_in = '0;
      end
      if (sweep_ff) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = sweep_idx_ff;
         mem_wr_data = '0;
      end else begin
         mem_wr_en   = res_wr_en;
         mem_wr_addr = res_wr_addr;
         mem_wr_data = {1'b1, res_wr_phys};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_RESET;
         shift_ff     <= SHIFT_RESET;
         sweep_ff     <= 1'b1;
         sweep_idx_ff <= '0;
      end else begin
         count_ff     <= count_in;
         shift_ff     <= shift_in;
         sweep_ff     <= sweep_in;
         sweep_idx_ff <= sweep_idx_in;
      end
   end

   nlbm_ram #(
      .WIDTH (MAP_W),
      .DEPTH (LOGICAL_ENTRIES)
   ) u_map (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (take),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nlbm_decode #(
      .LOGICAL_ENTRIES (LOGICAL_ENTRIES),
      .PHYS_BLOCK_BITS (PHYS_BLOCK_BITS)
   ) u_decode (
      .clock               (clock),
      .reset               (reset),
      .take                (take),
      .req_operation       (req_operation),
      .req_phys_block      (req_phys_block),
      .req_block_bad       (req_block_bad),
      .req_read_ok         (req_read_ok),
      .req_copy_a_low      (req_copy_a_low),
      .req_copy_a_high     (req_copy_a_high),
      .req_copy_b_low      (req_copy_b_low),
      .req_copy_b_high     (req_copy_b_high),
      .req_copy_c_low      (req_copy_c_low),
      .req_copy_c_high     (req_copy_c_high),
      .req_logical_address (req_logical_address),
      .req_length          (req_length),
      .block_shift         (shift_ff),
      .rd_addr             (rd_addr),
      .stage               (stage),
      .tag                 (tag),
      .addr                (addr),
      .len                 (len),
      .phys                (phys)
   );

   nlbm_resolve #(
      .LOGICAL_ENTRIES (LOGICAL_ENTRIES),
      .PHYS_BLOCK_BITS (PHYS_BLOCK_BITS)
   ) u_resolve (
      .clock                (clock),
      .reset                (reset),
      .stage                (stage),
      .tag                  (tag),
      .addr                 (addr),
      .len                  (len),
      .phys                 (phys),
      .rd_mapped            (rd_data[MAP_W-1]),
      .rd_phys              (rd_data[PHYS_BLOCK_BITS-1:0]),
      .logical_count        (count_ff),
      .block_shift          (shift_ff),
      .wr_en                (res_wr_en),
      .wr_addr              (res_wr_addr),
      .wr_phys              (res_wr_phys),
      .sweep_go             (sweep_go),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_logical_block    (rsp_logical_block),
      .rsp_physical_address (rsp_physical_address)
   );

endmodule

// ===== rtl/nlbm_chk.sv =====
// Port-level checker of the logical block map and its bind to the top level.
`include "nand_logical_block_map_defines.svh"

module nlbm_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic [3:0]                        rsp_status,
   input logic [nlbm_pkg::PA_OUT_W-1:0]     rsp_physical_address
);
   import nlbm_pkg::*;

   `NLBM_ASSERT_NXT(a_busy_after_accept, clock, reset, start && !busy, busy)
   `NLBM_ASSERT_LAT2(a_rsp_latency, clock, reset, start && !busy, rsp_valid)
   `NLBM_ASSERT_NXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `NLBM_ASSERT_IMP(a_rsp_code, clock, reset, rsp_valid, rsp_status <= ST_CLEARED)
   `NLBM_ASSERT_IMP(a_pa_xlate_only, clock, reset, rsp_valid && (rsp_status != ST_XLATED), rsp_physical_address == '0)

endmodule

bind nand_logical_block_map nlbm_chk u_nlbm_chk (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .rsp_valid            (rsp_valid),
   .rsp_status           (rsp_status),
   .rsp_physical_address (rsp_physical_address)
);
